// ===== sv/sfa_pkg.sv =====
package sfa_pkg;

   localparam int MaxSegments = 32;
   localparam int LenW        = 16;
   localparam int OwnW        = 16;
   localparam int IdxOutW     = 5;
   localparam int CsrIdxW     = 1;
   localparam int CsrDataW    = 16;

   localparam logic [1:0] ReqAlloc = 2'd0;
   localparam logic [1:0] ReqFree  = 2'd1;
   localparam logic [1:0] ReqInit  = 2'd2;

   localparam logic [1:0] StOk      = 2'd0;
   localparam logic [1:0] StNoFit   = 2'd1;
   localparam logic [1:0] StFull    = 2'd2;
   localparam logic [1:0] StNoOwner = 2'd3;

   localparam logic [CsrIdxW-1:0] CsrFitMode   = 1'd0;
   localparam logic [CsrIdxW-1:0] CsrTotalSize = 1'd1;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SCAN_RD,
      S_SCAN,
      S_DECIDE,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_MERGE_RD,
      S_MERGE,
      S_DONE
   } state_type;

   typedef struct packed {
      logic [LenW-1:0] len;
      logic [OwnW-1:0] owner;
      logic            free;
   } seg_type;

endpackage

// ===== sv/sfa_if.sv =====
interface sfa_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [15:0] owner_id;
   logic [15:0] request_size;
   modport source (output valid, req_type, owner_id, request_size, input ready);
   modport sink (input valid, req_type, owner_id, request_size, output ready);
endinterface

interface sfa_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [4:0]  segment_index;
   logic [15:0] chosen_size;
   modport source (output valid, status, segment_index, chosen_size, input ready);
   modport sink (input valid, status, segment_index, chosen_size, output ready);
endinterface

// ===== sv/sfa_ram.sv =====
module sfa_ram #(
   parameter int Width = 8,
   parameter int Depth = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ===== sv/segment_fit_allocator.sv =====
// channel   dir  handshake      payload
// req       in   valid/ready    req_type, owner_id, request_size
// rsp       out  valid/ready    status, segment_index, chosen_size
// csr       in   write enable   csr_index, csr_data
// Steps per word: allocate scans every table entry, and a split then shifts the
//   entries above the pick up by one; free scans up to the owner's segment (all
//   entries if none), then merges free runs over the whole table; init writes one
//   free segment. The single table RAM (one read, one write a cycle) sets the pace.
// Reset (synchronous) leaves one free segment of 65535 units.
// req_ready is low while a word is in work or its result waits on rsp.
module segment_fit_allocator #(
   parameter int MaxSegments = sfa_pkg::MaxSegments
) (
   input  logic                         clock,
   input  logic                         reset,
   sfa_req_if.sink                      req,
   sfa_rsp_if.source                    rsp,
   input  logic                         csr_we,
   input  logic [sfa_pkg::CsrIdxW-1:0]  csr_index,
   input  logic [sfa_pkg::CsrDataW-1:0] csr_data
);
   localparam int AW = $clog2(MaxSegments);
   localparam int CW = $clog2(MaxSegments + 1);
   localparam int SW = $bits(sfa_pkg::seg_type);

   sfa_pkg::state_type state_ff, state_in;
   logic        fit_mode_ff;
   logic [15:0] total_ff;
   logic [CW-1:0] count_ff, count_in;
   logic [1:0]  kind_ff, kind_in;
   logic [15:0] own_ff, own_in, size_ff, size_in;
   logic [CW-1:0] rp_ff, rp_in, wp_ff, wp_in;
   logic          found_ff, found_in;
   logic [AW-1:0] pick_ff, pick_in;
   logic [15:0]   plen_ff, plen_in;
   sfa_pkg::seg_type last_ff, last_in;
   logic          have_ff, have_in;
   logic [1:0]  st_ff, st_in;
   logic [4:0]  idx_ff, idx_in;
   logic [15:0] cs_ff, cs_in;
   logic        vld_ff, vld_in;

   logic          we;
   logic [AW-1:0] wa, ra;
   sfa_pkg::seg_type wd, rd;
   logic [SW-1:0] rd_raw;
   logic [16:0]   sum;

   sfa_ram #(.Width(SW), .Depth(MaxSegments)) u_tab (
      .clock(clock), .wr_en(we), .wr_addr(wa), .wr_data(wd),
      .rd_addr(ra), .rd_data(rd_raw));
   assign rd = sfa_pkg::seg_type'(rd_raw);
   assign sum = {1'b0, last_ff.len} + {1'b0, rd.len};

   assign req.ready = (state_ff == sfa_pkg::S_IDLE) && !vld_ff;
   assign rsp.valid = vld_ff;
   assign rsp.status = st_ff;
   assign rsp.segment_index = idx_ff;
   assign rsp.chosen_size = cs_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sfa_pkg::S_DONE;
         fit_mode_ff <= 1'b0;
         total_ff <= 16'hFFFF;
         count_ff <= CW'(1);
         vld_ff <= 1'b0;
         kind_ff <= sfa_pkg::ReqAlloc;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         vld_ff <= vld_in;
         kind_ff <= kind_in;
         if (csr_we) begin
            unique case (csr_index)
               sfa_pkg::CsrFitMode:   fit_mode_ff <= csr_data[0];
               sfa_pkg::CsrTotalSize: total_ff <= csr_data;
               default: ;
            endcase
         end
      end
      own_ff <= own_in; size_ff <= size_in; rp_ff <= rp_in; wp_ff <= wp_in;
      found_ff <= found_in; pick_ff <= pick_in; plen_ff <= plen_in;
      last_ff <= last_in; have_ff <= have_in;
      st_ff <= st_in; idx_ff <= idx_in; cs_ff <= cs_in;
   end

   always_comb begin
      state_in = state_ff; count_in = count_ff; vld_in = vld_ff; kind_in = kind_ff;
      own_in = own_ff; size_in = size_ff; rp_in = rp_ff; wp_in = wp_ff;
      found_in = found_ff; pick_in = pick_ff; plen_in = plen_ff;
      last_in = last_ff; have_in = have_ff;
      st_in = st_ff; idx_in = idx_ff; cs_in = cs_ff;
      we = 1'b0; wa = '0; wd = '0; ra = rp_ff[AW-1:0];
      if (vld_ff && rsp.ready) vld_in = 1'b0;
      unique case (state_ff)
         sfa_pkg::S_IDLE: begin
            if (req.valid && req.ready) begin
               kind_in = req.req_type; own_in = req.owner_id;
               size_in = req.request_size;
               rp_in = '0; found_in = 1'b0; pick_in = '0;
               st_in = sfa_pkg::StOk; idx_in = '0; cs_in = '0;
               unique case (req.req_type)
                  sfa_pkg::ReqAlloc: state_in = sfa_pkg::S_SCAN_RD;
                  sfa_pkg::ReqFree: begin
                     st_in = sfa_pkg::StNoOwner; state_in = sfa_pkg::S_SCAN_RD;
                  end
                  sfa_pkg::ReqInit: state_in = sfa_pkg::S_DONE;
                  default: begin vld_in = 1'b1; end
               endcase
            end
         end
         sfa_pkg::S_SCAN_RD: begin
            state_in = sfa_pkg::S_SCAN;
         end
         sfa_pkg::S_SCAN: begin
            state_in = sfa_pkg::S_SCAN_RD;
            if (kind_ff == sfa_pkg::ReqAlloc) begin
               if (rd.free && rd.len >= size_ff &&
                   (!found_ff || (!fit_mode_ff && rd.len < plen_ff) ||
                    (fit_mode_ff && rd.len > plen_ff))) begin
                  found_in = 1'b1; pick_in = rp_ff[AW-1:0]; plen_in = rd.len;
               end
            end else if (!rd.free && rd.owner == own_ff) begin
               we = 1'b1; wa = rp_ff[AW-1:0];
               wd = '{len: rd.len, owner: rd.owner, free: 1'b1};
               st_in = sfa_pkg::StOk; idx_in = 5'(rp_ff); cs_in = rd.len;
               rp_in = '0; wp_in = '0; have_in = 1'b0;
               state_in = sfa_pkg::S_MERGE_RD;
            end
            if (state_in == sfa_pkg::S_SCAN_RD) begin
               rp_in = rp_ff + CW'(1);
               if (rp_in >= count_ff) begin
                  if (kind_ff == sfa_pkg::ReqAlloc) state_in = sfa_pkg::S_DECIDE;
                  else begin
                     rp_in = '0; wp_in = '0; have_in = 1'b0;
                     state_in = sfa_pkg::S_MERGE_RD;
                  end
               end
            end
         end
         sfa_pkg::S_DECIDE: begin
            if (!found_ff) begin
               st_in = sfa_pkg::StNoFit; vld_in = 1'b1; state_in = sfa_pkg::S_IDLE;
            end else if (plen_ff == size_ff) begin
               we = 1'b1; wa = pick_ff;
               wd = '{len: size_ff, owner: own_ff, free: 1'b0};
               idx_in = 5'(pick_ff); cs_in = size_ff;
               vld_in = 1'b1; state_in = sfa_pkg::S_IDLE;
            end else if (count_ff >= CW'(MaxSegments)) begin
               st_in = sfa_pkg::StFull; vld_in = 1'b1; state_in = sfa_pkg::S_IDLE;
            end else begin
               wp_in = count_ff; rp_in = count_ff - CW'(1);
               state_in = sfa_pkg::S_SHIFT_RD;
            end
         end
         sfa_pkg::S_SHIFT_RD: begin
            if (wp_ff == CW'(pick_ff) + CW'(1)) begin
               we = 1'b1; wa = pick_ff;
               wd = '{len: plen_ff - size_ff, owner: own_ff, free: 1'b1};
               state_in = sfa_pkg::S_SHIFT_WR;
            end else begin
               state_in = sfa_pkg::S_SHIFT_WR;
            end
         end
         sfa_pkg::S_SHIFT_WR: begin
            we = 1'b1; wa = wp_ff[AW-1:0];
            if (wp_ff == CW'(pick_ff) + CW'(1)) begin
               wd = '{len: size_ff, owner: own_ff, free: 1'b0};
               idx_in = 5'(wp_ff); cs_in = plen_ff;
               count_in = count_ff + CW'(1);
               vld_in = 1'b1; state_in = sfa_pkg::S_IDLE;
            end else begin
               wd = rd;
               wp_in = wp_ff - CW'(1); rp_in = rp_ff - CW'(1);
               state_in = sfa_pkg::S_SHIFT_RD;
            end
         end
         sfa_pkg::S_MERGE_RD: begin
            if (rp_ff >= count_ff) begin
               if (have_ff) begin
                  we = 1'b1; wa = wp_ff[AW-1:0]; wd = last_ff;
               end
               count_in = wp_ff + (have_ff ? CW'(1) : CW'(0));
               vld_in = 1'b1; state_in = sfa_pkg::S_IDLE;
            end else begin
               state_in = sfa_pkg::S_MERGE;
            end
         end
         sfa_pkg::S_MERGE: begin
            if (have_ff && last_ff.free && rd.free) begin
               last_in.len = sum[16] ? 16'hFFFF : sum[15:0];
            end else begin
               if (have_ff) begin
                  we = 1'b1; wa = wp_ff[AW-1:0]; wd = last_ff;
                  wp_in = wp_ff + CW'(1);
               end
               last_in = rd; have_in = 1'b1;
            end
            rp_in = rp_ff + CW'(1);
            state_in = sfa_pkg::S_MERGE_RD;
         end
         sfa_pkg::S_DONE: begin
            we = 1'b1; wa = '0;
            wd = '{len: total_ff, owner: '0, free: 1'b1};
            count_in = CW'(1);
            if (kind_ff == sfa_pkg::ReqInit) begin
               st_in = sfa_pkg::StOk; idx_in = '0; cs_in = total_ff;
            end
            vld_in = (kind_ff == sfa_pkg::ReqInit);
            state_in = sfa_pkg::S_IDLE;
         end
         default: state_in = sfa_pkg::S_IDLE;
      endcase
   end
endmodule

// ===== sv/sfa_checker.sv =====
module sfa_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_status,
   input logic [4:0]  rsp_segment_index,
   input logic [15:0] rsp_chosen_size
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
      else $error("rsp dropped");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("ready while result pending");
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != sfa_pkg::StOk |-> rsp_chosen_size == 16'd0 &&
      rsp_segment_index == 5'd0)
      else $error("error result not cleared");
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("accepted twice");
endmodule

bind segment_fit_allocator sfa_checker u_sfa_checker (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_status(rsp.status), .rsp_segment_index(rsp.segment_index),
   .rsp_chosen_size(rsp.chosen_size));

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

   localparam int Limit = 20000;
   localparam logic [1:0] ReqUnknown = 2'd3;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [15:0] owner_id;
      logic [15:0] request_size;
   } req_word_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [4:0]  segment_index;
      logic [15:0] chosen_size;
   } rsp_word_type;

   typedef struct {
      req_word_type  req;
      logic          has_exp;
      rsp_word_type  exp;
   } table_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [sfa_pkg::CsrIdxW-1:0]  csr_index = '0;
   logic [sfa_pkg::CsrDataW-1:0] csr_data = '0;

   sfa_req_if req_ch ();
   sfa_rsp_if rsp_ch ();

   segment_fit_allocator DUT (
      .clock(clock), .reset(reset), .req(req_ch.sink), .rsp(rsp_ch.source),
      .csr_we(csr_we), .csr_index(csr_index), .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   // allocator model state
   logic [15:0] m_len [sfa_pkg::MaxSegments];
   logic [15:0] m_own [sfa_pkg::MaxSegments];
   logic        m_free [sfa_pkg::MaxSegments];
   int          m_count;
   logic        m_fit_worst;
   logic [15:0] m_total;

   rsp_word_type expected_rsp [$];
   int errors = 0;
   int idle_cycles = 0;
   int rsp_wait = 0;

   function automatic void merge_runs();
      int w;
      int s;
      w = 0;
      for (int r = 0; r < m_count; r++) begin
         if (w > 0 && m_free[w-1] && m_free[r]) begin
            s = m_len[w-1] + m_len[r];
            m_len[w-1] = (s > 65535) ? 16'hFFFF : 16'(s);
         end else begin
            m_len[w] = m_len[r];
            m_own[w] = m_own[r];
            m_free[w] = m_free[r];
            w++;
         end
      end
      m_count = w;
   endfunction

   function automatic rsp_word_type predict_segment(req_word_type q);
      rsp_word_type o;
      bit found;
      int pick;
      o = '0;
      found = 0;
      pick = 0;
      case (q.req_type)
         sfa_pkg::ReqAlloc: begin
            for (int i = 0; i < m_count; i++) begin
               if (m_free[i] && m_len[i] >= q.request_size) begin
                  if (!found || (!m_fit_worst && m_len[i] < m_len[pick]) ||
                      (m_fit_worst && m_len[i] > m_len[pick])) begin
                     found = 1;
                     pick = i;
                  end
               end
            end
            if (!found) begin
               o.status = sfa_pkg::StNoFit;
            end else if (m_len[pick] == q.request_size) begin
               m_free[pick] = 1'b0;
               m_own[pick] = q.owner_id;
               o.segment_index = 5'(pick);
               o.chosen_size = q.request_size;
            end else if (m_count >= sfa_pkg::MaxSegments) begin
               o.status = sfa_pkg::StFull;
            end else begin
               for (int i = m_count; i > pick + 1; i--) begin
                  m_len[i] = m_len[i-1];
                  m_own[i] = m_own[i-1];
                  m_free[i] = m_free[i-1];
               end
               o.segment_index = 5'(pick + 1);
               o.chosen_size = m_len[pick];
               m_len[pick+1] = q.request_size;
               m_own[pick+1] = q.owner_id;
               m_free[pick+1] = 1'b0;
               m_len[pick] = m_len[pick] - q.request_size;
               m_count++;
            end
         end
         sfa_pkg::ReqFree: begin
            o.status = sfa_pkg::StNoOwner;
            for (int i = 0; i < m_count; i++) begin
               if (!m_free[i] && m_own[i] == q.owner_id) begin
                  m_free[i] = 1'b1;
                  o.status = sfa_pkg::StOk;
                  o.segment_index = 5'(i);
                  o.chosen_size = m_len[i];
                  break;
               end
            end
            merge_runs();
         end
         sfa_pkg::ReqInit: begin
            m_count = 1;
            m_len[0] = m_total;
            m_own[0] = '0;
            m_free[0] = 1'b1;
            o.chosen_size = m_total;
         end
         default: ;
      endcase
      return o;
   endfunction

   task automatic write_csr(logic [sfa_pkg::CsrIdxW-1:0] idx, logic [15:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == sfa_pkg::CsrFitMode) m_fit_worst = value[0];
      else m_total = value;
   endtask

   task automatic send_word(req_word_type q, logic has_exp, rsp_word_type exp);
      rsp_word_type p;
      int gap;
      gap = $urandom_range(0, 9);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.req_type <= q.req_type;
      req_ch.owner_id <= q.owner_id;
      req_ch.request_size <= q.request_size;
      do @(posedge clock); while (!req_ch.ready);
      p = predict_segment(q);
      if (has_exp && p !== exp) begin
         errors++;
         if (errors <= 10)
            $display("table mismatch: typed %h predicted %h", exp, p);
      end
      expected_rsp.push_back(p);
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (150) @(posedge clock);
   endtask

   function automatic req_word_type rand_word(int owners, int maxsz);
      req_word_type q;
      int k;
      k = $urandom_range(0, 99);
      q.req_type = (k < 55) ? sfa_pkg::ReqAlloc : (k < 93) ? sfa_pkg::ReqFree :
                   (k < 97) ? sfa_pkg::ReqInit : ReqUnknown;
      q.owner_id = 16'($urandom_range(0, owners));
      q.request_size = ($urandom_range(0, 19) == 0) ? 16'($urandom)
                                                    : 16'($urandom_range(0, maxsz));
      return q;
   endfunction

   always @(posedge clock) begin
      rsp_word_type got;
      rsp_word_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         rsp_wait = 0;
      end else if (rsp_ch.valid && rsp_ch.ready) begin
         got = {rsp_ch.status, rsp_ch.segment_index, rsp_ch.chosen_size};
         if (expected_rsp.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected word %h", got);
         end else begin
            want = expected_rsp.pop_front();
            if (got !== want) begin
               errors++;
               if (errors <= 10)
                  $display("mismatch: status %0d/%0d index %0d/%0d size %0d/%0d",
                     want.status, got.status, want.segment_index,
                     got.segment_index, want.chosen_size, got.chosen_size);
            end
         end
         rsp_wait = $urandom_range(0, 9);
         rsp_ch.ready <= (rsp_wait == 0);
      end else if (rsp_wait > 0) begin
         rsp_wait--;
         rsp_ch.ready <= (rsp_wait == 0);
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= Limit) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   table_row_type directed [$];

   function automatic void add_row(logic [1:0] t, int own, int sz, logic he,
                                   logic [1:0] st, int ix, int cs);
      table_row_type r;
      r.req = '{t, 16'(own), 16'(sz)};
      r.has_exp = he;
      r.exp = '{st, 5'(ix), 16'(cs)};
      directed.push_back(r);
   endfunction

   initial begin
      req_ch.valid = 1'b0;
      req_ch.req_type = '0;
      req_ch.owner_id = '0;
      req_ch.request_size = '0;
      m_fit_worst = 1'b0;
      m_total = 16'hFFFF;
      m_count = 1;
      for (int i = 0; i < sfa_pkg::MaxSegments; i++) begin
         m_len[i] = '0;
         m_own[i] = '0;
         m_free[i] = 1'b0;
      end
      m_len[0] = 16'hFFFF;
      m_free[0] = 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      add_row(sfa_pkg::ReqFree, 16'hFFFF, 0, 1, sfa_pkg::StNoOwner, 0, 0);
      add_row(sfa_pkg::ReqAlloc, 16'hFFFF, 100, 1, sfa_pkg::StOk, 1, 65535);
      add_row(sfa_pkg::ReqAlloc, 0, 0, 1, sfa_pkg::StOk, 1, 65435);
      add_row(sfa_pkg::ReqAlloc, 7, 65535, 1, sfa_pkg::StNoFit, 0, 0);
      add_row(sfa_pkg::ReqAlloc, 5, 65435, 1, sfa_pkg::StOk, 0, 65435);
      add_row(sfa_pkg::ReqAlloc, 6, 1, 1, sfa_pkg::StNoFit, 0, 0);
      add_row(sfa_pkg::ReqFree, 0, 0, 1, sfa_pkg::StOk, 1, 0);
      add_row(sfa_pkg::ReqAlloc, 9, 0, 0, sfa_pkg::StOk, 0, 0);
      add_row(sfa_pkg::ReqFree, 5, 0, 1, sfa_pkg::StOk, 0, 65435);
      add_row(sfa_pkg::ReqFree, 16'hFFFF, 0, 0, sfa_pkg::StOk, 0, 0);
      add_row(sfa_pkg::ReqFree, 9, 0, 0, sfa_pkg::StOk, 0, 0);
      add_row(ReqUnknown, 16'hFFFF, 16'hFFFF, 1, sfa_pkg::StOk, 0, 0);
      add_row(sfa_pkg::ReqInit, 0, 0, 1, sfa_pkg::StOk, 0, 65535);
      for (int i = 0; i < directed.size(); i++)
         send_word(directed[i].req, directed[i].has_exp, directed[i].exp);
      drain();

      // fill the table to its limit with small splits, then hit table full
      write_csr(sfa_pkg::CsrTotalSize, 16'd1000);
      send_word('{sfa_pkg::ReqInit, 16'd0, 16'd0}, 1, '{sfa_pkg::StOk, 5'd0, 16'd1000});
      for (int i = 0; i < sfa_pkg::MaxSegments + 2; i++)
         send_word('{sfa_pkg::ReqAlloc, 16'(i + 1), 16'd3}, 0, '0);
      send_word('{sfa_pkg::ReqAlloc, 16'd77, 16'd1000}, 1,
                '{sfa_pkg::StNoFit, 5'd0, 16'd0});
      drain();

      for (int phase = 0; phase < 6; phase++) begin
         write_csr(sfa_pkg::CsrFitMode, 16'(phase[0]));
         write_csr(sfa_pkg::CsrTotalSize, (phase == 2) ? 16'd1 : (phase == 5) ? 16'hFFFF
                                                 : 16'($urandom_range(40, 4000)));
         send_word('{sfa_pkg::ReqInit, 16'd0, 16'd0}, 0, '0);
         for (int n = 0; n < 170; n++)
            send_word(rand_word((phase < 3) ? 12 : 65535,
                                (phase == 2) ? 2 : m_total / 6), 0, '0);
         drain();
      end
      if (errors == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
